>>> src/feedback_zoom_rotate_blend_defines.svh
// Assertion macros shared by the checker of the feedback zoom rotate blend block.
`ifndef FEEDBACK_ZOOM_ROTATE_BLEND_DEFINES_SVH
`define FEEDBACK_ZOOM_ROTATE_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FZRB_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("fzrb assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FZRB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("fzrb assertion failed");

`endif

>>> src/fzrb_pkg.sv
// Package with the shared types, constants and blend function of the feedback blend block.
`timescale 1ns / 1ps

package fzrb_pkg;

	localparam int PIXEL_W        = 24;
	localparam int FIX_W          = 32;
	localparam int CFG_INDEX_W    = 3;
	localparam int FRAME_WIDTH_W  = 9;
	localparam int FRAME_HEIGHT_W = 8;

	localparam logic [PIXEL_W-1:0] BLEND_MASK = 24'hfcfcff;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 9'd320;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 8'd240;
	localparam logic [FIX_W-1:0]          STEP_X_RST       = 32'h0001_0000;
	localparam logic [FIX_W-1:0]          STEP_Y_RST       = 32'h0000_0000;
	localparam logic [FIX_W-1:0]          ORIGIN_X_RST     = 32'h0000_0000;
	localparam logic [FIX_W-1:0]          ORIGIN_Y_RST     = 32'h0000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_STEP_X       = 3'd2,
		REG_STEP_Y       = 3'd3,
		REG_ORIGIN_X     = 3'd4,
		REG_ORIGIN_Y     = 3'd5
	} reg_index_t;

	// Control flags that travel with each word from the front to the back.
	typedef struct packed {
		logic wen;
		logic bank;
		logic frame_end;
	} item_ctl_t;

	// Packed masked blend: three quarters of the previous pixel plus one quarter of the source.
	function automatic logic [PIXEL_W-1:0] blend(input logic [PIXEL_W-1:0] prev,
		input logic [PIXEL_W-1:0] src);
		logic [PIXEL_W-1:0] pm;
		logic [PIXEL_W-1:0] sm;
		logic [PIXEL_W+1:0] sum;
		pm = prev & BLEND_MASK;
		sm = src & BLEND_MASK;
		sum = {2'b00, pm} + {1'b0, pm, 1'b0} + {2'b00, sm};
		return sum[PIXEL_W+1:2];
	endfunction

endpackage

>>> src/fzrb_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module fzrb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/fzrb_fifo.sv
// Small register queue used between the front and back and at the result side.
`timescale 1ns / 1ps

module fzrb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wptr_q;
	logic [PTRW-1:0]  rptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_pop;

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTRW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTRW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

>>> src/fzrb_front.sv
// Front part: configuration registers, raster counters, affine cursor and address computation.
`timescale 1ns / 1ps

module fzrb_front #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240,
	parameter int AW         = 17,
	parameter int QDEPTH     = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [fzrb_pkg::PIXEL_W-1:0]      pixel_in,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fzrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fzrb_pkg::FIX_W-1:0]        cfg_data,
	input  logic                              clearing,
	input  logic                              mid_pop,
	output logic                              out_valid,
	output logic [AW-1:0]                     out_raddr,
	output logic [AW-1:0]                     out_waddr,
	output logic [fzrb_pkg::PIXEL_W-1:0]      out_src,
	output fzrb_pkg::item_ctl_t               out_ctl
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int PW   = WW + HW;
	localparam int XW   = 16 + WW + 1;
	localparam int SW   = 18 + WW + HW;
	localparam int WSW  = RW + WW + 1;
	localparam int CNTW = $clog2(QDEPTH + 1);

	logic [fzrb_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [fzrb_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [fzrb_pkg::FIX_W-1:0]          step_x_q;
	logic [fzrb_pkg::FIX_W-1:0]          step_y_q;
	logic [fzrb_pkg::FIX_W-1:0]          origin_x_q;
	logic [fzrb_pkg::FIX_W-1:0]          origin_y_q;

	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic                       bank_q;
	logic [fzrb_pkg::FIX_W-1:0] row_start_x_q;
	logic [fzrb_pkg::FIX_W-1:0] row_start_y_q;
	logic [fzrb_pkg::FIX_W-1:0] cursor_x_q;
	logic [fzrb_pkg::FIX_W-1:0] cursor_y_q;
	logic [CNTW-1:0]            cnt_q;

	logic [WW-1:0] w_use;
	logic [HW-1:0] h_use;
	logic          accept;
	logic          row_end;
	logic          frame_done;

	logic                         valid_s1;
	logic [fzrb_pkg::PIXEL_W-1:0] src_s1;
	logic signed [15:0]           ix_s1;
	logic signed [15:0]           iy_s1;
	logic [WW-1:0]                w_s1;
	logic [HW-1:0]                h_s1;
	logic [RW-1:0]                row_s1;
	logic [CW-1:0]                col_s1;
	logic                         bank_s1;
	logic                         fend_s1;

	logic                         valid_s2;
	logic [fzrb_pkg::PIXEL_W-1:0] src_s2;
	logic signed [XW-1:0]         rprod_s2;
	logic [RW+WW-1:0]             wprod_s2;
	logic [PW-1:0]                area_s2;
	logic signed [15:0]           ix_s2;
	logic [CW-1:0]                col_s2;
	logic                         bank_s2;
	logic                         fend_s2;

	logic                         valid_s3;
	logic [AW-1:0]                raddr_s3;
	logic [AW-1:0]                waddr_s3;
	logic [fzrb_pkg::PIXEL_W-1:0] src_s3;
	fzrb_pkg::item_ctl_t          ctl_s3;

	logic signed [SW-1:0] idx;
	logic signed [SW-1:0] area_sx;
	logic [WSW-1:0]       wsum;
	logic [AW-1:0]        raddr_c;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign full      = clearing || (cnt_q == CNTW'(QDEPTH));

	always_comb begin
		if (frame_width_q == '0) begin
			w_use = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_use = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_use = HW'(MAX_HEIGHT);
		end else begin
			h_use = HW'(frame_height_q);
		end
	end

	assign row_end    = (32'(col_q) + 32'd1) >= 32'(w_use);
	assign frame_done = row_end && ((32'(row_q) + 32'd1) >= 32'(h_use));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= fzrb_pkg::FRAME_WIDTH_RST;
			frame_height_q <= fzrb_pkg::FRAME_HEIGHT_RST;
			step_x_q       <= fzrb_pkg::STEP_X_RST;
			step_y_q       <= fzrb_pkg::STEP_Y_RST;
			origin_x_q     <= fzrb_pkg::ORIGIN_X_RST;
			origin_y_q     <= fzrb_pkg::ORIGIN_Y_RST;
		end else if (cfg_valid) begin
			unique case (fzrb_pkg::reg_index_t'(cfg_index))
				fzrb_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[fzrb_pkg::FRAME_WIDTH_W-1:0];
				end
				fzrb_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[fzrb_pkg::FRAME_HEIGHT_W-1:0];
				end
				fzrb_pkg::REG_STEP_X: begin
					step_x_q <= cfg_data;
				end
				fzrb_pkg::REG_STEP_Y: begin
					step_y_q <= cfg_data;
				end
				fzrb_pkg::REG_ORIGIN_X: begin
					origin_x_q <= cfg_data;
				end
				fzrb_pkg::REG_ORIGIN_Y: begin
					origin_y_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// At a row end the row start turns by the rotated step; at a frame end it reloads the origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			bank_q        <= 1'b0;
			row_start_x_q <= fzrb_pkg::ORIGIN_X_RST;
			row_start_y_q <= fzrb_pkg::ORIGIN_Y_RST;
			cursor_x_q    <= fzrb_pkg::ORIGIN_X_RST;
			cursor_y_q    <= fzrb_pkg::ORIGIN_Y_RST;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_done) begin
					row_q         <= '0;
					bank_q        <= ~bank_q;
					row_start_x_q <= origin_x_q;
					row_start_y_q <= origin_y_q;
					cursor_x_q    <= origin_x_q;
					cursor_y_q    <= origin_y_q;
				end else begin
					row_q         <= row_q + 1'b1;
					row_start_x_q <= row_start_x_q - step_y_q;
					row_start_y_q <= row_start_y_q + step_x_q;
					cursor_x_q    <= row_start_x_q - step_y_q;
					cursor_y_q    <= row_start_y_q + step_x_q;
				end
			end else begin
				col_q      <= col_q + 1'b1;
				cursor_x_q <= cursor_x_q + step_x_q;
				cursor_y_q <= cursor_y_q + step_y_q;
			end
		end
	end

	// Each accepted word holds one queue slot until the back takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			cnt_q    <= cnt_q + CNTW'(accept) - CNTW'(mid_pop);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		idx     = SW'(rprod_s2) + SW'(ix_s2);
		area_sx = $signed(SW'(area_s2));
		wsum    = WSW'(wprod_s2) + WSW'(col_s2);
		if (idx < 0) begin
			raddr_c = '0;
		end else if (idx >= area_sx) begin
			raddr_c = AW'(area_s2 - 1'b1);
		end else begin
			raddr_c = AW'(idx);
		end
	end

	always_ff @(posedge clk) begin
		src_s1  <= pixel_in;
		ix_s1   <= $signed(cursor_x_q[31:16]);
		iy_s1   <= $signed(cursor_y_q[31:16]);
		w_s1    <= w_use;
		h_s1    <= h_use;
		row_s1  <= row_q;
		col_s1  <= col_q;
		bank_s1 <= bank_q;
		fend_s1 <= frame_done;

		src_s2   <= src_s1;
		rprod_s2 <= XW'(iy_s1) * XW'($signed({1'b0, w_s1}));
		wprod_s2 <= (RW + WW)'(row_s1) * (RW + WW)'(w_s1);
		area_s2  <= PW'(w_s1) * PW'(h_s1);
		ix_s2    <= ix_s1;
		col_s2   <= col_s1;
		bank_s2  <= bank_s1;
		fend_s2  <= fend_s1;

		raddr_s3         <= raddr_c;
		waddr_s3         <= AW'(wsum);
		src_s3           <= src_s2;
		ctl_s3.wen       <= SW'(wsum) < SW'(area_s2);
		ctl_s3.bank      <= bank_s2;
		ctl_s3.frame_end <= fend_s2;
	end

	assign out_valid = valid_s3;
	assign out_raddr = raddr_s3;
	assign out_waddr = waddr_s3;
	assign out_src   = src_s3;
	assign out_ctl   = ctl_s3;

endmodule

>>> src/fzrb_back.sv
// Back part: frame store pair, previous-frame fetch with write forwarding, blend and store write.
`timescale 1ns / 1ps

module fzrb_back #(
	parameter int AW     = 17,
	parameter int DEPTH  = 76800,
	parameter int ODEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mq_empty,
	input  logic [AW-1:0]                mq_raddr,
	input  logic [AW-1:0]                mq_waddr,
	input  logic [fzrb_pkg::PIXEL_W-1:0] mq_src,
	input  fzrb_pkg::item_ctl_t          mq_ctl,
	output logic                         mq_pop,
	input  logic                         out_pop,
	output logic                         res_valid,
	output logic [fzrb_pkg::PIXEL_W-1:0] res_pixel,
	output logic                         res_frame_end,
	output logic                         clearing
);

	localparam int OCW = $clog2(ODEPTH + 1);

	logic [OCW-1:0] ocnt_q;
	logic           clearing_q;
	logic [AW-1:0]  clr_addr_q;
	logic           issue;

	logic                         valid_b1;
	logic [AW-1:0]                waddr_b1;
	logic [fzrb_pkg::PIXEL_W-1:0] src_b1;
	fzrb_pkg::item_ctl_t          ctl_b1;
	logic                         hit_b1;
	logic [fzrb_pkg::PIXEL_W-1:0] fwd_b1;

	logic [fzrb_pkg::PIXEL_W-1:0] rdata_a;
	logic [fzrb_pkg::PIXEL_W-1:0] rdata_b;
	logic [fzrb_pkg::PIXEL_W-1:0] prev;
	logic [fzrb_pkg::PIXEL_W-1:0] result;
	logic                         we_a;
	logic                         we_b;
	logic [AW-1:0]                st_waddr;
	logic [fzrb_pkg::PIXEL_W-1:0] st_wdata;

	assign issue    = !mq_empty && (ocnt_q != OCW'(ODEPTH));
	assign mq_pop   = issue;
	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q     <= '0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			valid_b1   <= 1'b0;
			hit_b1     <= 1'b0;
		end else begin
			ocnt_q   <= ocnt_q + OCW'(issue) - OCW'(out_pop);
			valid_b1 <= issue;
			// A read issued in the same cycle as the older word's write sees stale data.
			hit_b1   <= issue && valid_b1 && ctl_b1.wen && (mq_ctl.bank != ctl_b1.bank)
				&& (mq_raddr == waddr_b1);
			if (clearing_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_b1 <= mq_waddr;
		src_b1   <= mq_src;
		ctl_b1   <= mq_ctl;
		fwd_b1   <= result;
	end

	assign prev   = hit_b1 ? fwd_b1 : (ctl_b1.bank ? rdata_b : rdata_a);
	assign result = fzrb_pkg::blend(prev, src_b1);

	// A word that reads one store writes the other.
	assign we_a     = clearing_q || (valid_b1 && ctl_b1.wen && ctl_b1.bank);
	assign we_b     = clearing_q || (valid_b1 && ctl_b1.wen && !ctl_b1.bank);
	assign st_waddr = clearing_q ? clr_addr_q : waddr_b1;
	assign st_wdata = clearing_q ? '0 : result;

	fzrb_ram #(
		.WIDTH(fzrb_pkg::PIXEL_W),
		.DEPTH(DEPTH)
	) u_store_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(mq_raddr),
		.rdata(rdata_a)
	);

	fzrb_ram #(
		.WIDTH(fzrb_pkg::PIXEL_W),
		.DEPTH(DEPTH)
	) u_store_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(mq_raddr),
		.rdata(rdata_b)
	);

	assign res_valid     = valid_b1;
	assign res_pixel     = result;
	assign res_frame_end = ctl_b1.frame_end;

endmodule

>>> src/feedback_zoom_rotate_blend.sv
// Top level of the video feedback blend with affine zoom and rotation.
`timescale 1ns / 1ps

// The block takes one source pixel per clock while full is low and gives one blended pixel per clock
// once warm while pop keeps the result queue from filling; a word's result passes the front stages
// s1, s2 and s3, the middle queue, the back stage b1 and the result queue. The rate is set by
// the frame stores, which take one read and one write per clock, and a write still in flight is
// forwarded to a read issued right behind it, so that no word waits on the word before it. After
// reset, full stays high while both frame stores are cleared one entry per cycle; configuration
// writes are taken during that pass.
module feedback_zoom_rotate_blend #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [fzrb_pkg::PIXEL_W-1:0]      pixel_in,
	output logic                              empty,
	input  logic                              pop,
	output logic [fzrb_pkg::PIXEL_W-1:0]      pixel_out,
	output logic                              frame_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fzrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fzrb_pkg::FIX_W-1:0]        cfg_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int QDEPTH = 8;
	localparam int ODEPTH = 4;
	localparam int MQW    = 2 * AW + fzrb_pkg::PIXEL_W + $bits(fzrb_pkg::item_ctl_t);
	localparam int OQW    = fzrb_pkg::PIXEL_W + 1;

	logic                         clearing;
	logic                         f_valid;
	logic [AW-1:0]                f_raddr;
	logic [AW-1:0]                f_waddr;
	logic [fzrb_pkg::PIXEL_W-1:0] f_src;
	fzrb_pkg::item_ctl_t          f_ctl;

	logic [MQW-1:0]               mq_wdata;
	logic [MQW-1:0]               mq_rdata;
	logic                         mq_empty;
	logic                         mq_pop;
	logic [AW-1:0]                mq_raddr;
	logic [AW-1:0]                mq_waddr;
	logic [fzrb_pkg::PIXEL_W-1:0] mq_src;
	fzrb_pkg::item_ctl_t          mq_ctl;

	logic                         res_valid;
	logic [fzrb_pkg::PIXEL_W-1:0] res_pixel;
	logic                         res_frame_end;
	logic [OQW-1:0]               oq_rdata;
	logic                         out_pop;

	assign out_pop  = pop && !empty;
	assign mq_wdata = {f_raddr, f_waddr, f_src, f_ctl};
	assign {mq_raddr, mq_waddr, mq_src, mq_ctl} = mq_rdata;
	assign {pixel_out, frame_end} = oq_rdata;

	fzrb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.AW        (AW),
		.QDEPTH    (QDEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel_in (pixel_in),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.clearing (clearing),
		.mid_pop  (mq_pop),
		.out_valid(f_valid),
		.out_raddr(f_raddr),
		.out_waddr(f_waddr),
		.out_src  (f_src),
		.out_ctl  (f_ctl)
	);

	fzrb_fifo #(
		.WIDTH(MQW),
		.DEPTH(QDEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_valid),
		.pop   (mq_pop),
		.wdata (mq_wdata),
		.rdata (mq_rdata),
		.empty (mq_empty)
	);

	fzrb_back #(
		.AW    (AW),
		.DEPTH (DEPTH),
		.ODEPTH(ODEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mq_empty     (mq_empty),
		.mq_raddr     (mq_raddr),
		.mq_waddr     (mq_waddr),
		.mq_src       (mq_src),
		.mq_ctl       (mq_ctl),
		.mq_pop       (mq_pop),
		.out_pop      (out_pop),
		.res_valid    (res_valid),
		.res_pixel    (res_pixel),
		.res_frame_end(res_frame_end),
		.clearing     (clearing)
	);

	fzrb_fifo #(
		.WIDTH(OQW),
		.DEPTH(ODEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.pop   (pop),
		.wdata ({res_pixel, res_frame_end}),
		.rdata (oq_rdata),
		.empty (empty)
	);

endmodule

>>> src/fzrb_checker.sv
// Port-level checker for the feedback blend block and its bind to the top level.
`timescale 1ns / 1ps
`include "feedback_zoom_rotate_blend_defines.svh"

module fzrb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [fzrb_pkg::PIXEL_W-1:0] pixel_out,
	input logic                         frame_end
);

	logic [4:0] outstanding_q;
	logic       accepted;
	logic       delivered;

	assign accepted  = push && !full;
	assign delivered = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 5'(accepted) - 5'(delivered);
		end
	end

	`FZRB_ASSERT_NEXT(a_word_stays, clk, arst_n, !empty && !pop, !empty)
	`FZRB_ASSERT_NEXT(a_word_holds, clk, arst_n, !empty && !pop, $stable(pixel_out) && $stable(frame_end))
	`FZRB_ASSERT_IMPL(a_no_phantom, clk, arst_n, !empty, outstanding_q != 5'd0)
	`FZRB_ASSERT_IMPL(a_clear_after_reset, clk, arst_n, $rose(arst_n), full)

endmodule

bind feedback_zoom_rotate_blend fzrb_checker u_fzrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.pixel_out(pixel_out),
	.frame_end(frame_end)
);
